// File: hdl/tfn_pkg.sv
// tfn_pkg: shared types and constants for the triangle face normal engine
// no dependencies
`default_nettype none
package tfn_pkg;
    localparam int VertexSlots = 1024;
    localparam int SlotW = 10;
    localparam int CoordW = 16;
    localparam int NormW = 16;
    localparam logic CmdWrite = 1'b0;
    localparam logic CmdTri = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [SlotW-1:0]   vertex_slot;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic [SlotW-1:0]   corner_a;
        logic [SlotW-1:0]   corner_b;
        logic [SlotW-1:0]   corner_c;
        logic               last_triangle;
    } t_in_item;

    typedef struct packed {
        logic signed [NormW-1:0] normal_x;
        logic signed [NormW-1:0] normal_y;
        logic signed [NormW-1:0] normal_z;
        logic               degenerate;
        logic [SlotW-1:0]   out_corner_a;
        logic [SlotW-1:0]   out_corner_b;
        logic [SlotW-1:0]   out_corner_c;
        logic               end_of_mesh;
    } t_out_item;

    // triangle job passed from the front to the back
    typedef struct packed {
        logic signed [34:0] cx;
        logic signed [34:0] cy;
        logic signed [34:0] cz;
        logic [SlotW-1:0]   ca;
        logic [SlotW-1:0]   cb;
        logic [SlotW-1:0]   cc;
        logic               last;
    } t_job;
endpackage
`default_nettype wire

// File: hdl/tfn_if.sv
// tfn_if: valid/ready channel carrying one payload item
// depends on tfn_pkg for payload types
`default_nettype none
interface tfn_in_if;
    import tfn_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tfn_out_if;
    import tfn_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/triangle_face_normal_engine.sv
// triangle_face_normal_engine: top level, front, job queue and back
// depends on tfn_pkg, tfn_if, tfn_front, tfn_queue, tfn_back
//
// channel   dir  payload
// s_in      in   cmd, slot, position, corners, last_triangle
// m_out     out  normal, degenerate, corners, end_of_mesh
//
// a triangle holds the front for three store reads on one port, products and
// handoff, and the back from accept to accept for four setup steps, a bit-serial
// root of 32 steps, three divides of one setup, quotient steps and a store step
// each, and one output state; a zero normal skips the root and the divides
// reset clears control only; the vertex store has no reset
// the queue lets the front read vertices while the back still divides
`default_nettype none
module triangle_face_normal_engine import tfn_pkg::*; #(
    parameter int VERTEX_SLOTS = VertexSlots
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    tfn_in_if.sink   s_in,
    tfn_out_if.source m_out
);
    logic w_fv, w_fr, w_bv, w_br;
    t_job w_fj, w_bj;

    tfn_front #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_item(s_in.data), .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fj));
    tfn_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fj),
        .o_valid(w_bv), .i_ready(w_br), .o_job(w_bj));
    tfn_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_bv), .o_ready(w_br), .i_job(w_bj),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_item(m_out.data));
endmodule
`default_nettype wire

// File: hdl/tfn_front.sv
// tfn_front: vertex store, classifies items, reads corners and forms the cross product
// depends on tfn_pkg
`default_nettype none
module tfn_front import tfn_pkg::*; #(
    parameter int VERTEX_SLOTS = VertexSlots
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in_item i_item,
    output logic      o_job_valid,
    input  wire logic i_job_ready,
    output t_job      o_job
);
    localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    // slot fold by reciprocal multiplication, exact for every slot value
    localparam int RecipShift = SlotW + AW + 1;
    localparam int ProdW = SlotW + RecipShift;
    localparam longint unsigned SlotRecip =
        ((64'd1 << RecipShift) + 64'(VERTEX_SLOTS) - 64'd1) / 64'(VERTEX_SLOTS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_RA = 6'b000010, S_RB = 6'b000100,
        S_RC = 6'b001000, S_MUL = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3*CoordW-1:0] r_mem [VERTEX_SLOTS];
    logic [3*CoordW-1:0] r_rd;
    logic [AW-1:0] w_raddr, w_waddr;
    t_in_item r_item;
    logic signed [16:0] r_e1 [3];
    logic signed [16:0] r_e2 [3];
    logic signed [CoordW-1:0] r_a [3];
    logic signed [33:0] r_p [6];
    t_job r_job;

    function automatic logic [AW-1:0] slot_idx(input logic [SlotW-1:0] s);
        logic [ProdW-1:0] q;
        logic [ProdW-1:0] t;
        q = (ProdW'(s) * ProdW'(SlotRecip)) >> RecipShift;
        t = ProdW'(s) - q * ProdW'(VERTEX_SLOTS);
        return t[AW-1:0];
    endfunction

    assign w_waddr = slot_idx(i_item.vertex_slot);
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        case (r_state)
            S_RA:    w_raddr = slot_idx(r_item.corner_b);
            S_RB:    w_raddr = slot_idx(r_item.corner_c);
            default: w_raddr = slot_idx(i_item.corner_a);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_item.cmd == CmdWrite) begin
            r_mem[w_waddr] <= {i_item.pos_x, i_item.pos_y, i_item.pos_z};
        end
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid && i_item.cmd == CmdTri) n_state = S_RA;
            S_RA:    n_state = S_RB;
            S_RB:    n_state = S_RC;
            S_RC:    n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT:   if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) r_item <= i_item;
        if (r_state == S_RA) begin
            r_a[0] <= r_rd[47:32];
            r_a[1] <= r_rd[31:16];
            r_a[2] <= r_rd[15:0];
        end
        if (r_state == S_RB) begin
            r_e1[0] <= 17'(signed'(r_rd[47:32])) - 17'(r_a[0]);
            r_e1[1] <= 17'(signed'(r_rd[31:16])) - 17'(r_a[1]);
            r_e1[2] <= 17'(signed'(r_rd[15:0])) - 17'(r_a[2]);
        end
        if (r_state == S_RC) begin
            r_e2[0] <= 17'(signed'(r_rd[47:32])) - 17'(r_a[0]);
            r_e2[1] <= 17'(signed'(r_rd[31:16])) - 17'(r_a[1]);
            r_e2[2] <= 17'(signed'(r_rd[15:0])) - 17'(r_a[2]);
        end
        if (r_state == S_MUL) begin
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
        end
    end

    always_comb begin
        r_job.cx = 35'(r_p[0]) - 35'(r_p[1]);
        r_job.cy = 35'(r_p[2]) - 35'(r_p[3]);
        r_job.cz = 35'(r_p[4]) - 35'(r_p[5]);
        r_job.ca = r_item.corner_a;
        r_job.cb = r_item.corner_b;
        r_job.cc = r_item.corner_c;
        r_job.last = r_item.last_triangle;
    end

    assign o_job_valid = (r_state == S_OUT);
    assign o_job = r_job;

    a_job_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> r_state == S_OUT) else $error("job valid outside output state");
    a_job_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid && $stable(o_job))
        else $error("stalled job changed");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("ready while busy");
endmodule
`default_nettype wire

// File: hdl/tfn_queue.sv
// tfn_queue: two-entry job queue between front and back
// depends on tfn_pkg
`default_nettype none
module tfn_queue import tfn_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("pointer mismatch");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_wp != r_rp) else $error("pointer mismatch one");
endmodule
`default_nettype wire

// File: hdl/tfn_back.sv
// tfn_back: normalizes a cross product: scale, length square, root, three divides
// depends on tfn_pkg
`default_nettype none
module tfn_back import tfn_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out_item o_item
);
    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001, B_ABS = 8'b00000010, B_SHF = 8'b00000100,
        B_SQ = 8'b00001000, B_SUM = 8'b00010000, B_ROOT = 8'b00100000,
        B_DIV = 8'b01000000, B_OUT = 8'b10000000
    } t_bstate;

    // divide step count value that marks the setup cycle of one component
    localparam logic [4:0] DivSetup = 5'd17;

    t_bstate r_st, n_st;
    t_job r_job;
    logic [2:0] r_neg;
    logic [33:0] r_mag [3];
    logic [30:0] r_sm [3];
    logic [61:0] r_sq [3];
    // root iteration state
    logic [63:0] r_rem;
    logic [31:0] r_root;
    logic [5:0] r_cnt;
    // divide state
    logic [1:0] r_di;
    logic [46:0] r_num;
    logic [32:0] r_den;
    logic [15:0] r_q;
    logic [4:0] r_dc;
    // cap of exactly 16384 needs bit 14 set; track the full value
    logic [15:0] r_full [3];
    logic [33:0] w_m;
    logic [5:0] w_lz;
    logic w_deg;
    logic [65:0] w_trial;
    logic [49:0] w_dnum;
    logic w_borrow;
    logic [15:0] w_qn;
    logic [15:0] w_cap;

    assign w_m = (r_mag[0] > r_mag[1]) ?
                 ((r_mag[0] > r_mag[2]) ? r_mag[0] : r_mag[2]) :
                 ((r_mag[1] > r_mag[2]) ? r_mag[1] : r_mag[2]);
    assign w_deg = (w_m == 34'd0);

    always_comb begin
        w_lz = 6'd0;
        for (int i = 0; i < 34; i++) begin
            if (w_m[i]) w_lz = 6'(i);
        end
    end

    assign o_ready = (r_st == B_IDLE);
    assign o_valid = (r_st == B_OUT);

    always_comb begin
        n_st = r_st;
        case (r_st)
            B_IDLE:  if (i_valid) n_st = B_ABS;
            B_ABS:   n_st = B_SHF;
            B_SHF:   n_st = w_deg ? B_OUT : B_SQ;
            B_SQ:    n_st = B_SUM;
            B_SUM:   n_st = B_ROOT;
            B_ROOT:  if (r_cnt == 6'd0) n_st = B_DIV;
            B_DIV:   if (r_di == 2'd2 && r_dc == 5'd0) n_st = B_OUT;
            B_OUT:   if (i_ready) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= B_IDLE;
        else r_st <= n_st;
    end

    // restoring root: one result bit per cycle
    assign w_trial = {2'b00, r_rem} - (66'({r_root, 2'b01}) << (2*r_cnt));
    // restoring divide: one quotient bit per cycle
    assign w_dnum = {3'b000, r_num} - (50'(r_den) << r_dc);
    assign w_borrow = w_dnum[49];
    assign w_qn = {r_q[14:0], !w_borrow};
    assign w_cap = (w_qn > 16'd16384) ? 16'd16384 : w_qn;

    always_ff @(posedge i_clk) begin
        case (r_st)
            B_IDLE: r_job <= i_job;
            B_ABS: begin
                r_neg <= {r_job.cz[34], r_job.cy[34], r_job.cx[34]};
                r_mag[0] <= 34'(r_job.cx[34] ? -r_job.cx : r_job.cx);
                r_mag[1] <= 34'(r_job.cy[34] ? -r_job.cy : r_job.cy);
                r_mag[2] <= 34'(r_job.cz[34] ? -r_job.cz : r_job.cz);
            end
            B_SHF: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_lz >= 6'd30) r_sm[i] <= 31'(r_mag[i] >> (w_lz - 6'd30));
                    else r_sm[i] <= 31'(r_mag[i] << (6'd30 - w_lz));
                end
            end
            B_SQ: begin
                for (int i = 0; i < 3; i++) r_sq[i] <= 62'(r_sm[i]) * 62'(r_sm[i]);
            end
            B_SUM: begin
                r_rem <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
                r_root <= 32'd0;
                r_cnt <= 6'd31;
            end
            B_ROOT: begin
                if (!w_trial[65]) begin
                    r_rem <= w_trial[63:0];
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_root <= {r_root[30:0], 1'b0};
                end
                if (r_cnt != 6'd0) r_cnt <= r_cnt - 6'd1;
                else begin
                    r_di <= 2'd0;
                    r_dc <= DivSetup;
                    r_q <= 16'd0;
                    r_num <= 47'(r_sm[0]) << 15;
                end
            end
            B_DIV: begin
                if (r_dc == DivSetup) begin
                    // rounding term and divisor 2*root
                    r_den <= {r_root, 1'b0};
                    r_num <= r_num + 47'(r_root);
                    r_dc <= 5'd16;
                end else if (r_dc != 5'd0) begin
                    if (!w_borrow) r_num <= w_dnum[46:0];
                    r_q <= w_qn;
                    r_dc <= r_dc - 5'd1;
                end else begin
                    r_di <= r_di + 2'd1;
                    r_dc <= DivSetup;
                    r_q <= 16'd0;
                    r_num <= (r_di == 2'd0) ? 47'(r_sm[1]) << 15 : 47'(r_sm[2]) << 15;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == B_SHF) for (int i = 0; i < 3; i++) r_full[i] <= 16'd0;
        if (r_st == B_DIV && r_dc == 5'd0) r_full[r_di] <= w_cap;
    end

    always_comb begin
        o_item.normal_x = r_neg[0] ? -r_full[0] : r_full[0];
        o_item.normal_y = r_neg[1] ? -r_full[1] : r_full[1];
        o_item.normal_z = r_neg[2] ? -r_full[2] : r_full[2];
        o_item.degenerate = (r_full[0] == 16'd0) && (r_full[1] == 16'd0) &&
                            (r_full[2] == 16'd0) && (r_sm[0] == 31'd0) &&
                            (r_sm[1] == 31'd0) && (r_sm[2] == 31'd0);
        o_item.out_corner_a = r_job.ca;
        o_item.out_corner_b = r_job.cb;
        o_item.out_corner_c = r_job.cc;
        o_item.end_of_mesh = r_job.last;
    end

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item)) else $error("result changed");
    a_root_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == B_SUM |=> r_cnt == 6'd31 && r_root == 32'd0)
        else $error("root start");
endmodule
`default_nettype wire

// File: test/triangle_face_normal_engine_checker.sv
// triangle_face_normal_engine_checker: watches both channels, predicts each face normal
// and compares it with the block's output; depends on tfn_pkg and tfn_if
`timescale 1ns / 100ps
module triangle_face_normal_engine_checker import tfn_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    tfn_in_if.sink   s_in,
    tfn_out_if.sink  s_out,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_normals_seen,
    output int       o_degenerate_seen
);
    logic signed [CoordW-1:0] vtx_x [VertexSlots];
    logic signed [CoordW-1:0] vtx_y [VertexSlots];
    logic signed [CoordW-1:0] vtx_z [VertexSlots];
    t_out_item normal_queue[$];

    function automatic t_out_item face_normal(t_in_item it);
        t_out_item r;
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] cr [3];
        logic [63:0] mag [3];
        logic [63:0] m, len2, rem, root, bt, q;
        int sa, sb, sc;
        sa = it.corner_a % VertexSlots;
        sb = it.corner_b % VertexSlots;
        sc = it.corner_c % VertexSlots;
        e1[0] = 64'(vtx_x[sb]) - 64'(vtx_x[sa]);
        e1[1] = 64'(vtx_y[sb]) - 64'(vtx_y[sa]);
        e1[2] = 64'(vtx_z[sb]) - 64'(vtx_z[sa]);
        e2[0] = 64'(vtx_x[sc]) - 64'(vtx_x[sa]);
        e2[1] = 64'(vtx_y[sc]) - 64'(vtx_y[sa]);
        e2[2] = 64'(vtx_z[sc]) - 64'(vtx_z[sa]);
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
            if (mag[i] > m) m = mag[i];
        end
        r = '0;
        r.out_corner_a = it.corner_a;
        r.out_corner_b = it.corner_b;
        r.out_corner_c = it.corner_c;
        r.end_of_mesh = it.last_triangle;
        if (m == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        while (m >= 64'd1 << 31) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < 64'd1 << 30) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        // bit-by-bit integer square root
        rem = len2;
        root = 0;
        bt = 64'd1 << 62;
        while (bt > len2) bt >>= 2;
        while (bt != 0) begin
            if (rem >= root + bt) begin
                rem -= root + bt;
                root = (root >> 1) + bt;
            end else begin
                root >>= 1;
            end
            bt >>= 2;
        end
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 15) + root) / (root << 1);
            if (q > 16384) q = 16384;
            if (cr[i] < 0) q = -q;
            case (i)
                0: r.normal_x = q[15:0];
                1: r.normal_y = q[15:0];
                default: r.normal_z = q[15:0];
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_normals_seen <= 0;
            o_degenerate_seen <= 0;
            o_pending <= 0;
        end else begin
            if (s_in.valid && s_in.ready) begin
                if (s_in.data.cmd == CmdWrite) begin
                    vtx_x[s_in.data.vertex_slot % VertexSlots] = s_in.data.pos_x;
                    vtx_y[s_in.data.vertex_slot % VertexSlots] = s_in.data.pos_y;
                    vtx_z[s_in.data.vertex_slot % VertexSlots] = s_in.data.pos_z;
                end else begin
                    normal_queue.push_back(face_normal(s_in.data));
                end
            end
            if (s_out.valid && s_out.ready) begin
                got = s_out.data;
                o_normals_seen <= o_normals_seen + 1;
                if (got.degenerate) o_degenerate_seen <= o_degenerate_seen + 1;
                if (normal_queue.size() == 0) begin
                    $display("%0t: unexpected normal, got %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = normal_queue.pop_front();
                    if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y
                            || got.normal_z !== want.normal_z
                            || got.degenerate !== want.degenerate
                            || got.out_corner_a !== want.out_corner_a
                            || got.out_corner_b !== want.out_corner_b
                            || got.out_corner_c !== want.out_corner_c
                            || got.end_of_mesh !== want.end_of_mesh) begin
                        $display("%0t: normal mismatch, expected %p, got %p",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= normal_queue.size();
        end
    end
endmodule

// File: test/triangle_face_normal_engine_test.sv
// triangle_face_normal_engine_test: drives vertex writes and triangles into the engine
// depends on tfn_pkg, tfn_if, the engine and triangle_face_normal_engine_checker
`timescale 1ns / 100ps
module triangle_face_normal_engine_test;
    import tfn_pkg::*;

    localparam int CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int fail_count, pending, normals_seen, degenerate_seen;
    int cycle_count = 0;
    int hold_off = 0;
    bit hold_done = 1'b0;
    int tri_count = 0;
    bit written [VertexSlots];
    int written_list[$];

    tfn_in_if  in_ch ();
    tfn_out_if out_ch ();

    triangle_face_normal_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    triangle_face_normal_engine_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .s_out(out_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_normals_seen(normals_seen), .o_degenerate_seen(degenerate_seen)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else if (i_rst_n && tri_count == 30 && !hold_done) begin
            hold_off <= 2000;
            hold_done <= 1'b1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [9:0] any_written();
        return 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    task automatic send(t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (it.cmd == CmdWrite && !written[it.vertex_slot]) begin
            written[it.vertex_slot] = 1'b1;
            written_list.push_back(it.vertex_slot);
        end
        if (it.cmd == CmdTri) tri_count++;
    endtask

    task automatic gap();
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic put_vertex(logic [9:0] s, logic [15:0] x, logic [15:0] y,
                              logic [15:0] z);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom}));
        it.cmd = CmdWrite;
        it.vertex_slot = s;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        send(it);
    endtask

    task automatic put_tri(logic [9:0] a, logic [9:0] b, logic [9:0] c, logic l);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom}));
        it.cmd = CmdTri;
        it.corner_a = a;
        it.corner_b = b;
        it.corner_c = c;
        it.last_triangle = l;
        send(it);
    endtask

    initial begin
        int burst;
        logic [9:0] a, b, c;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, axis-aligned faces, and a flat triangle
        put_vertex(10'd0, 16'sd0, 16'sd0, 16'sd0);
        put_vertex(10'd1, 16'h7fff, 16'h7fff, 16'h7fff);
        put_vertex(10'd2, 16'h8000, 16'h8000, 16'h8000);
        put_vertex(10'd1023, 16'h7fff, 16'h8000, 16'h0000);
        put_vertex(10'd3, 16'sd1, 16'sd0, 16'sd0);
        put_vertex(10'd4, 16'sd0, 16'sd1, 16'sd0);
        put_vertex(10'd5, 16'h8000, 16'h7fff, 16'h8000);
        put_tri(10'd0, 10'd3, 10'd4, 1'b0);
        put_tri(10'd0, 10'd1, 10'd2, 1'b0);
        put_tri(10'd0, 10'd0, 10'd0, 1'b0);
        put_tri(10'd1, 10'd2, 10'd1023, 1'b1);
        put_tri(10'd2, 10'd1023, 10'd5, 1'b0);
        put_tri(10'd1023, 10'd5, 10'd1, 1'b1);
        put_tri(10'd5, 10'd3, 10'd0, 1'b0);
        put_vertex(10'd3, 16'sd0, 16'sd0, 16'sd1);
        put_tri(10'd0, 10'd3, 10'd4, 1'b1);

        for (int n = 0; n < 500; n += burst) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                if (written_list.size() < 3 || $urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 3))
                        0: put_vertex(10'($urandom), 16'($urandom_range(0, 3) << 14),
                                      16'($urandom), 16'($urandom));
                        1: put_vertex(10'($urandom_range(0, 31)), 16'($urandom),
                                      16'($urandom), 16'($urandom));
                        default: put_vertex(10'($urandom), 16'($urandom),
                                            16'($urandom), 16'($urandom));
                    endcase
                end else begin
                    a = any_written();
                    b = any_written();
                    c = ($urandom_range(0, 9) == 0) ? a : any_written();
                    put_tri(a, b, c, $urandom_range(0, 7) == 0);
                end
            end
            if ($urandom_range(0, 3) != 0) gap();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d triangles (%0d degenerate) over %0d written slots",
                 normals_seen, degenerate_seen, written_list.size());
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/tfn_pkg.sv
hdl/tfn_if.sv
hdl/tfn_front.sv
hdl/tfn_queue.sv
hdl/tfn_back.sv
hdl/triangle_face_normal_engine.sv
test/triangle_face_normal_engine_checker.sv
test/triangle_face_normal_engine_test.sv
